/* rtl/gregorian_date_difference_days_top_macros.svh */
// assertion macros for the date difference block
`ifndef GREGORIAN_DATE_DIFFERENCE_DAYS_TOP_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_DAYS_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define GDD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GDD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gdd_pkg.sv */
package gdd_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 22;
    localparam int DAYNUM_W   = 23;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic                ok;
        logic [DAYNUM_W-1:0] num;
    } date_num_t;

    // 400/100/4 rule, divide by 25 through a reciprocal
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [11:0] quarter;
        logic [22:0] prod;
        logic [7:0]  q25;
        logic        by25;
        logic        by4;
        quarter = year[YEAR_W-1:2];
        prod    = 23'(quarter) * 23'd1311;
        q25     = prod[22:15];
        by25    = (quarter == 12'(q25) * 12'd25);
        by4     = (year[1:0] == 2'b00);
        return ((year[3:0] == 4'b0000) && by25) || (by4 && !by25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the month, counting the year from march
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [8:0] offs;
        case (month)
            4'd3:    offs = 9'd0;
            4'd4:    offs = 9'd31;
            4'd5:    offs = 9'd61;
            4'd6:    offs = 9'd92;
            4'd7:    offs = 9'd122;
            4'd8:    offs = 9'd153;
            4'd9:    offs = 9'd184;
            4'd10:   offs = 9'd214;
            4'd11:   offs = 9'd245;
            4'd12:   offs = 9'd275;
            4'd1:    offs = 9'd306;
            4'd2:    offs = 9'd337;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

/* rtl/gdd_day_number.sv */
module gdd_day_number (
    input  logic [gdd_pkg::YEAR_W-1:0]  year,
    input  logic [gdd_pkg::MONTH_W-1:0] month,
    input  logic [gdd_pkg::DAY_W-1:0]   day,
    output gdd_pkg::date_num_t          result
);
    import gdd_pkg::*;

    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [14:0]        adj_year;
    logic [12:0]        q4;
    logic [23:0]        q100_prod;
    logic [7:0]         q100;
    logic [5:0]         q400;

    always_comb begin
        leap      = is_leap(year);
        len       = month_len(month, leap);
        adj_year  = 15'(year) + 15'd400 - ((month <= MONTH_FEB) ? 15'd1 : 15'd0);
        q4        = adj_year[14:2];
        q100_prod = 24'(q4) * 24'd1311;
        q100      = q100_prod[22:15];
        q400      = q100[7:2];

        result.ok  = (year <= MAX_YEAR) && (month >= MONTH_JAN) && (month <= MONTH_DEC)
                     && (day != '0) && (day <= len);
        result.num = DAYNUM_W'(adj_year) * 23'd365 + DAYNUM_W'(q4) - DAYNUM_W'(q100)
                     + DAYNUM_W'(q400) + DAYNUM_W'(month_offset(month))
                     + DAYNUM_W'(day) - 23'd1;
    end

endmodule

/* rtl/gdd_count.sv */
module gdd_count (
    input  gdd_pkg::date_num_t           start_num,
    input  gdd_pkg::date_num_t           end_num,
    input  logic                         include_end_day,
    output logic [gdd_pkg::COUNT_W-1:0]  day_count,
    output logic                         date_invalid
);
    import gdd_pkg::*;

    logic [DAYNUM_W-1:0] diff;
    logic [DAYNUM_W:0]   total;

    always_comb begin
        diff  = (end_num.num > start_num.num) ? (end_num.num - start_num.num) : '0;
        total = {1'b0, diff} + (DAYNUM_W + 1)'(include_end_day);

        date_invalid = !(start_num.ok && end_num.ok);
        if (date_invalid) begin
            day_count = '0;
        end else if (total > (DAYNUM_W + 1)'(COUNT_MAX)) begin
            day_count = COUNT_MAX;
        end else begin
            day_count = total[COUNT_W-1:0];
        end
    end

endmodule

/* rtl/gregorian_date_difference_days_top.sv */
// Days between two Gregorian dates. Each input item carries a start and an end
// date; the result is the day count from start to end (0 when the start is not
// before the end), plus one when include_end_day is set. A month outside 1 to
// 12, a day outside the month, or a year above 9999 gives date_invalid with a
// count of 0. One item is accepted per cycle unless the output is stalled by m_tready:
// the item is captured in an input register, both dates go through the
// closed-form day-number logic in one pass, and the count lands in the output
// register. Write include_end_day only while no item is in flight.
module gregorian_date_difference_days_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic                             cfg_wdata,   // include_end_day
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day
    input  logic [gdd_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gdd_pkg::OUT_TDATA_W-1:0]  m_tdata,     // day_count
    output logic                             m_tuser      // date_invalid
);
    import gdd_pkg::*;

    logic                   include_end_day_reg;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [IN_TDATA_W-1:0]  in_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_invalid_reg;
    logic                   out_ready;
    logic                   in_ready;
    logic                   out_load;

    date_num_t              start_num;
    date_num_t              end_num;
    logic [COUNT_W-1:0]     count_calc;
    logic                   invalid_calc;

    always_comb begin
        out_ready      = !out_valid_reg || m_tready;
        in_ready       = !in_valid_reg || out_ready;
        out_load       = out_ready && in_valid_reg;
        in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_end_day_reg <= 1'b0;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wen) begin
                include_end_day_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (out_load) begin
            out_count_reg   <= count_calc;
            out_invalid_reg <= invalid_calc;
        end
    end

    gdd_day_number u_start (
        .year   (in_data_reg[13:0]),
        .month  (in_data_reg[17:14]),
        .day    (in_data_reg[22:18]),
        .result (start_num)
    );

    gdd_day_number u_end (
        .year   (in_data_reg[36:23]),
        .month  (in_data_reg[40:37]),
        .day    (in_data_reg[45:41]),
        .result (end_num)
    );

    gdd_count u_count (
        .start_num       (start_num),
        .end_num         (end_num),
        .include_end_day (include_end_day_reg),
        .day_count       (count_calc),
        .date_invalid    (invalid_calc)
    );

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - COUNT_W){1'b0}}, out_count_reg};
    assign m_tuser  = out_invalid_reg;

endmodule

/* rtl/gdd_checker.sv */
`include "gregorian_date_difference_days_top_macros.svh"

module gdd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gdd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser
);
    import gdd_pkg::*;

    // an invalid date pair never carries a count
    `GDD_ASSERT_NOW(a_invalid_zero, aclk, aresetn, m_tvalid && m_tuser,
        m_tdata == '0, "invalid item with non-zero count")

    // padding above the count stays clear
    `GDD_ASSERT_NOW(a_pad_clear, aclk, aresetn, m_tvalid,
        m_tdata[OUT_TDATA_W-1:COUNT_W] == '0, "padding bits set in result")

    // a stalled result holds
    `GDD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind gregorian_date_difference_days_top gdd_checker u_gdd_checker (.*);

/* verif/tb_gregorian_date_difference_days_top.sv */
`timescale 1ns / 100ps

module tb_gregorian_date_difference_days_top;

    localparam int unsigned YEAR_LIMIT   = 9999;
    localparam int unsigned COUNT_CEIL   = 4194303;
    localparam int          LONG_HOLD    = 300;
    localparam int          PHASE_ITEMS  = 310;
    localparam int          RANDOM_PHASES = 6;
    localparam int          CASE_COUNT   = 25;

    localparam int unsigned MONTH_LENGTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned DAYS_BEFORE_MONTH [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int unsigned SPECIAL_YEARS [13] =
        '{0, 4, 100, 400, 1600, 1700, 1800, 1900, 2000, 2100, 2400, 9996, 9999};

    typedef struct packed {
        logic        invalid;
        logic [21:0] count;
    } day_result_t;

    typedef struct packed {
        int unsigned sy, sm, sd, ey, em, ed;
        bit          typed;
        int unsigned count;
        bit          invalid;
    } date_case_t;

    // count at include_end_day 0; valid typed rows get the register added
    localparam date_case_t DATE_CASES [CASE_COUNT] = '{
        '{2000, 1, 1, 2000, 1, 1, 1, 0, 0},
        '{2000, 1, 2, 2000, 1, 1, 1, 0, 0},
        '{2000, 1, 1, 2000, 1, 2, 1, 1, 0},
        '{2000, 1, 1, 2001, 1, 1, 1, 366, 0},
        '{1900, 1, 1, 1901, 1, 1, 1, 365, 0},
        '{0, 1, 1, 9999, 12, 31, 0, 0, 0},
        '{9999, 12, 31, 0, 1, 1, 1, 0, 0},
        '{0, 2, 29, 0, 3, 1, 1, 1, 0},
        '{1900, 2, 29, 2000, 1, 1, 1, 0, 1},
        '{2000, 2, 29, 2004, 2, 29, 0, 0, 0},
        '{2000, 0, 1, 2000, 1, 1, 1, 0, 1},
        '{2000, 13, 1, 2000, 1, 1, 1, 0, 1},
        '{2000, 1, 1, 2000, 15, 31, 1, 0, 1},
        '{2000, 1, 0, 2000, 1, 1, 1, 0, 1},
        '{2000, 1, 1, 2000, 4, 31, 1, 0, 1},
        '{10000, 1, 1, 2000, 1, 1, 1, 0, 1},
        '{2000, 1, 1, 16383, 12, 31, 1, 0, 1},
        '{1, 1, 1, 9999, 12, 31, 0, 0, 0},
        '{2100, 2, 28, 2100, 3, 1, 1, 1, 0},
        '{2400, 2, 28, 2400, 3, 1, 1, 2, 0},
        '{2023, 12, 31, 2024, 1, 1, 1, 1, 0},
        '{9999, 12, 31, 9999, 12, 31, 1, 0, 0},
        '{1999, 3, 15, 2023, 7, 4, 0, 0, 0},
        '{2000, 2, 30, 2000, 3, 1, 1, 0, 1},
        '{8191, 12, 31, 9999, 1, 31, 0, 0, 0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wen;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [gdd_pkg::IN_TDATA_W-1:0]  s_tdata;   // start y/m/d, end y/m/d
    logic        m_tvalid;
    logic        m_tready;
    logic [gdd_pkg::OUT_TDATA_W-1:0] m_tdata;   // day_count
    logic        m_tuser;                       // date_invalid

    day_result_t due_results [$];
    bit          end_day_inclusive;
    bit          quiet;
    bit          hold_long;
    bit          send_bursty = 1'b1;
    bit          recv_bursty = 1'b1;
    int          fault_count;

    gregorian_date_difference_days_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        return (m == 2 && leap_year(y)) ? 29 : MONTH_LENGTH[m-1];
    endfunction

    function automatic bit date_valid(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        return y <= YEAR_LIMIT && m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, m);
    endfunction

    // days since 1 jan of year 0, year 0 being a leap year
    function automatic longint calendar_ordinal(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        longint days;
        days = 365 * longint'(y);
        if (y > 0)
            days += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
        days += DAYS_BEFORE_MONTH[m-1] + d - 1;
        if (m > 2 && leap_year(y))
            days += 1;
        return days;
    endfunction

    function automatic logic [47:0] pack_dates(input logic [13:0] sy, input logic [3:0] sm,
                                               input logic [4:0] sd, input logic [13:0] ey,
                                               input logic [3:0] em, input logic [4:0] ed);
        return {2'b00, ed, em, ey, sd, sm, sy};
    endfunction

    function automatic day_result_t predict_span(input logic [47:0] td, input bit inclusive);
        day_result_t res;
        longint      span;
        int unsigned sy, sm, sd, ey, em, ed;
        sy = 32'(td[13:0]);
        sm = 32'(td[17:14]);
        sd = 32'(td[22:18]);
        ey = 32'(td[36:23]);
        em = 32'(td[40:37]);
        ed = 32'(td[45:41]);
        res = '0;
        if (!date_valid(sy, sm, sd) || !date_valid(ey, em, ed)) begin
            res.invalid = 1'b1;
            return res;
        end
        span = calendar_ordinal(ey, em, ed) - calendar_ordinal(sy, sm, sd);
        if (span < 0)
            span = 0;
        span += inclusive;
        if (span > COUNT_CEIL)
            span = COUNT_CEIL;
        res.count = span[21:0];
        return res;
    endfunction

    task automatic break_date(inout int unsigned y, inout int unsigned m, inout int unsigned d);
        case ($urandom_range(0, 4))
            0: y = $urandom_range(YEAR_LIMIT + 1, 16383);
            1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
            2: d = 0;
            3: d = month_days(y, m) + 1;
            default: begin
                y = $urandom_range(0, 2499) * 4 + $urandom_range(1, 3);
                m = 2;
                d = 29;
            end
        endcase
    endtask

    task automatic random_dates(output logic [47:0] td);
        int unsigned sy, sm, sd, ey, em, ed, kind, tmp;
        kind = $urandom_range(0, 99);
        sy = $urandom_range(0, YEAR_LIMIT);
        sm = $urandom_range(1, 12);
        sd = $urandom_range(1, month_days(sy, sm));
        ey = $urandom_range(0, YEAR_LIMIT);
        em = $urandom_range(1, 12);
        ed = $urandom_range(1, month_days(ey, em));
        if (kind >= 50 && kind < 65) begin
            // leap boundaries and month ends, dates close together
            sy = SPECIAL_YEARS[$urandom_range(0, 12)];
            ey = (sy >= YEAR_LIMIT) ? sy : sy + $urandom_range(0, 1);
            sm = $urandom_range(1, 12);
            sd = $urandom_range(0, 1) ? month_days(sy, sm) : $urandom_range(1, month_days(sy, sm));
            em = $urandom_range(1, 12);
            ed = $urandom_range(0, 1) ? month_days(ey, em) : $urandom_range(1, month_days(ey, em));
        end else if (kind >= 65 && kind < 75) begin
            if ($urandom_range(0, 1)) begin
                ey = sy;
                em = sm;
                ed = sd;
            end else if (calendar_ordinal(sy, sm, sd) < calendar_ordinal(ey, em, ed)) begin
                tmp = sy; sy = ey; ey = tmp;
                tmp = sm; sm = em; em = tmp;
                tmp = sd; sd = ed; ed = tmp;
            end
        end else if (kind >= 75 && kind < 90) begin
            if ($urandom_range(0, 1))
                break_date(sy, sm, sd);
            else
                break_date(ey, em, ed);
        end
        td = pack_dates(14'(sy), 4'(sm), 5'(sd), 14'(ey), 4'(em), 5'(ed));
        if (kind >= 90)
            td = {2'b00, 14'($urandom), 32'($urandom)};
    endtask

    task automatic offer_dates(input logic [47:0] td, input bit typed,
                               input day_result_t typed_res);
        if (!quiet && send_bursty && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= td;
        do @(posedge aclk); while (!s_tready);
        due_results.push_back(typed ? typed_res : predict_span(td, end_day_inclusive));
        if ($urandom_range(0, 59) == 0)
            send_bursty = !send_bursty;
    endtask

    task automatic write_end_day(input bit value);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        end_day_inclusive = value;
    endtask

    task automatic run_date_cases();
        day_result_t typed_res;
        date_case_t  c;
        for (int k = 0; k < CASE_COUNT; k++) begin
            c = DATE_CASES[k];
            typed_res.invalid = c.invalid;
            typed_res.count   = c.invalid ? 22'd0 : 22'(c.count + end_day_inclusive);
            offer_dates(pack_dates(14'(c.sy), 4'(c.sm), 5'(c.sd), 14'(c.ey), 4'(c.em),
                                   5'(c.ed)), c.typed, typed_res);
        end
    endtask

    initial begin
        logic [47:0] td;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_date_cases();
        write_end_day(1'b1);
        run_date_cases();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_end_day(phase % 2 == 1);
            if (phase == 2)
                hold_long = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_dates(td);
                offer_dates(td, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fault_count == 0 && due_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                hold_long = 1'b0;
            end else if (!quiet && recv_bursty && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
            if ($urandom_range(0, 59) == 0)
                recv_bursty = !recv_bursty;
        end
    end

    always @(posedge aclk) begin
        day_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("unexpected item: day_count %0d date_invalid %0d",
                       m_tdata[21:0], m_tuser);
                fault_count++;
            end else begin
                want = due_results.pop_front();
                if (m_tdata[21:0] !== want.count) begin
                    $error("day_count: expected %0d, got %0d", want.count, m_tdata[21:0]);
                    fault_count++;
                end
                if (m_tuser !== want.invalid) begin
                    $error("date_invalid: expected %0d, got %0d", want.invalid, m_tuser);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
